### rtl/core/png_chunk_crc32_framer_macros.svh
// ----------------------------------------------------------------------------
// PNG chunk framer assertion macros
// Concurrent check wrappers on clk with rst_n as the disable condition.
// ----------------------------------------------------------------------------
`ifndef PNG_CHUNK_CRC32_FRAMER_MACROS_SVH
`define PNG_CHUNK_CRC32_FRAMER_MACROS_SVH

`ifndef ASSERT_OFF

`define PCF_ASSERT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcf assertion failed");

`define PCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcf assertion failed");

`else

`define PCF_ASSERT(lbl, ante, cons)

`define PCF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### rtl/core/pcf_pkg.sv
// ----------------------------------------------------------------------------
// PNG chunk framer package
// Field widths, command codes, CRC-32 constants and the byte fold function.
// ----------------------------------------------------------------------------
package pcf_pkg;

  localparam int MODE_W = 2;
  localparam int LEN_W  = 31;
  localparam int TYPE_W = 32;
  localparam int BYTE_W = 8;
  localparam int CRC_W  = 32;
  localparam int IDX_W  = 3;

  localparam logic [MODE_W-1:0] MODE_START   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_PAYLOAD = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FINISH  = 2'd2;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  typedef logic [IDX_W-1:0] idx_t;

  localparam idx_t START_LAST_IDX   = 3'd7;
  localparam idx_t PAYLOAD_LAST_IDX = 3'd0;
  localparam idx_t FINISH_LAST_IDX  = 3'd3;

  typedef enum logic [2:0] {
    KIND_START   = 3'b001,
    KIND_PAYLOAD = 3'b010,
    KIND_FINISH  = 3'b100
  } kind_t;

  function automatic logic [CRC_W-1:0] crc_fold(input logic [CRC_W-1:0] c,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] v;
    v = c ^ {{(CRC_W-BYTE_W){1'b0}}, b};
    for (int k = 0; k < BYTE_W; k++) begin
      v = v[0] ? (CRC_POLY ^ (v >> 1)) : (v >> 1);
    end
    return v;
  endfunction

endpackage

### rtl/core/pcf_in_if.sv
// ----------------------------------------------------------------------------
// PNG chunk framer command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface pcf_in_if;
  import pcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  chunk_length;
  logic [TYPE_W-1:0] chunk_type;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, mode, chunk_length, chunk_type, data_byte, input ready);
  modport sink   (input valid, mode, chunk_length, chunk_type, data_byte, output ready);
endinterface

### rtl/core/pcf_out_if.sv
// ----------------------------------------------------------------------------
// PNG chunk framer byte channel
// Valid/ready channel carrying one framed byte item.
// ----------------------------------------------------------------------------
interface pcf_out_if;
  import pcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

### rtl/core/png_chunk_crc32_framer.sv
// ----------------------------------------------------------------------------
// PNG chunk framer with CRC-32
// Each command item lands in an item register and is sent out as bytes, one
// per cycle while the output is not stalled, through a registered output
// stage; payload bytes stream at one per cycle likewise. A start item sends
// eight bytes (length then type) and a finish item four (inverted CRC,
// big-endian, last on the final byte). The pace is set by the single
// byte-wide output register. The reflected CRC-32 folds each type and
// payload byte as it moves into the output register. Payload and finish
// items with no chunk open, and mode three, are dropped on acceptance. Each
// byte passes through the item register and then the output register.
// ----------------------------------------------------------------------------
`include "png_chunk_crc32_framer_macros.svh"

module png_chunk_crc32_framer (
  input  logic      clk,
  input  logic      rst_n,
  pcf_in_if.sink    in_ch,
  pcf_out_if.source out_ch
);
  import pcf_pkg::*;

  logic              item_v_r, item_v_nxt;
  kind_t             kind_r, kind_nxt;
  idx_t              idx_r, idx_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [TYPE_W-1:0] type_r, type_nxt;
  logic [BYTE_W-1:0] data_r, data_nxt;
  logic [CRC_W-1:0]  crc_r, crc_nxt;
  logic              open_r, open_nxt;
  logic              out_v_r, out_v_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;

  logic              in_fire;
  logic              take;
  logic              emit;
  logic              done;
  idx_t              last_idx;
  logic [1:0]        sel;
  logic [CRC_W-1:0]  emit_word;
  logic [CRC_W-1:0]  emit_shift;
  logic [BYTE_W-1:0] emit_byte;

  assign in_fire = in_ch.valid && in_ch.ready;
  assign take    = in_fire && ((in_ch.mode == MODE_START) ||
                   (open_r && ((in_ch.mode == MODE_PAYLOAD) || (in_ch.mode == MODE_FINISH))));
  assign emit    = item_v_r && (!out_v_r || out_ch.ready);
  assign done    = emit && (idx_r == last_idx);

  assign in_ch.ready     = !item_v_r || done;
  assign out_ch.valid    = out_v_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    unique case (kind_r)
      KIND_START:   last_idx = START_LAST_IDX;
      KIND_PAYLOAD: last_idx = PAYLOAD_LAST_IDX;
      KIND_FINISH:  last_idx = FINISH_LAST_IDX;
      default:      last_idx = PAYLOAD_LAST_IDX;
    endcase
  end

  // pick the big-endian byte of the current word
  assign sel = ~idx_r[1:0];

  always_comb begin
    unique case (kind_r)
      KIND_START:   emit_word = idx_r[2] ? type_r : {1'b0, len_r};
      KIND_FINISH:  emit_word = ~crc_r;
      KIND_PAYLOAD: emit_word = {{(CRC_W-BYTE_W){1'b0}}, data_r};
      default:      emit_word = {{(CRC_W-BYTE_W){1'b0}}, data_r};
    endcase
  end

  assign emit_shift = (kind_r == KIND_PAYLOAD) ? emit_word : (emit_word >> {sel, 3'b000});
  assign emit_byte  = emit_shift[BYTE_W-1:0];

  always_comb begin
    item_v_nxt   = item_v_r;
    kind_nxt     = kind_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    type_nxt     = type_r;
    data_nxt     = data_r;
    crc_nxt      = crc_r;
    open_nxt     = open_r;
    out_v_nxt    = out_v_r;
    out_byte_nxt = out_byte_r;
    out_last_nxt = out_last_r;

    if (emit) begin
      out_v_nxt    = 1'b1;
      out_byte_nxt = emit_byte;
      out_last_nxt = (kind_r == KIND_FINISH) && (idx_r == FINISH_LAST_IDX);
      idx_nxt      = idx_r + idx_t'(1);
      unique case (kind_r)
        KIND_START: begin
          if (idx_r == '0) begin
            crc_nxt = CRC_INIT;
          end else if (idx_r[2]) begin
            crc_nxt = crc_fold(crc_r, emit_byte);
          end
        end
        KIND_PAYLOAD: crc_nxt = crc_fold(crc_r, emit_byte);
        KIND_FINISH: begin
          if (done) begin
            crc_nxt = CRC_INIT;
          end
        end
        default: crc_nxt = crc_r;
      endcase
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    if (done) begin
      item_v_nxt = 1'b0;
    end

    if (take) begin
      item_v_nxt = 1'b1;
      idx_nxt    = '0;
      len_nxt    = in_ch.chunk_length;
      type_nxt   = in_ch.chunk_type;
      data_nxt   = in_ch.data_byte;
      priority if (in_ch.mode == MODE_START) begin
        kind_nxt = KIND_START;
        open_nxt = 1'b1;
      end else if (in_ch.mode == MODE_PAYLOAD) begin
        kind_nxt = KIND_PAYLOAD;
      end else begin
        kind_nxt = KIND_FINISH;
        open_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r <= 1'b0;
      kind_r   <= KIND_PAYLOAD;
      idx_r    <= '0;
      crc_r    <= CRC_INIT;
      open_r   <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      item_v_r <= item_v_nxt;
      kind_r   <= kind_nxt;
      idx_r    <= idx_nxt;
      crc_r    <= crc_nxt;
      open_r   <= open_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    type_r     <= type_nxt;
    data_r     <= data_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `PCF_ASSERT(a_idle_ready, !item_v_r, in_ch.ready)
  `PCF_ASSERT(a_idx_range, item_v_r, idx_r <= last_idx)
  `PCF_ASSERT_NEXT(a_crc_reseed, done && (kind_r == KIND_FINISH), (crc_r == CRC_INIT) && out_last_r)
  `PCF_ASSERT_NEXT(a_payload_load, take && (in_ch.mode == MODE_PAYLOAD), item_v_r && (kind_r == KIND_PAYLOAD) && (idx_r == '0))

endmodule
